>>> sv/pcg32_bounded_index_unit_assert.svh
// assertion macros shared by the pcg32 bounded index unit
`ifndef PCG32_BOUNDED_INDEX_UNIT_ASSERT_SVH
`define PCG32_BOUNDED_INDEX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define PCG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCG_ASSERT_IMPL(lbl, ante, cons, msg)
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/pcg32_pkg.sv
// types, constants and helper functions of the pcg32 bounded index unit
package pcg32_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned WORD_W  = 32;

    // lcg multiplier split into 32-bit halves
    localparam logic [WORD_W-1:0]  LCG_MULT_LO = 32'h4C95_7F2D;
    localparam logic [WORD_W-1:0]  LCG_MULT_HI = 32'h5851_F42D;
    localparam logic [STATE_W-1:0] STATE_RESET = 64'h853C_49E6_748F_EA9B;
    localparam logic [STATE_W-1:0] INC_RESET   = 64'hDA3E_39CB_94B9_5BDB;

    // xsh-rr output constants
    localparam int unsigned XS_SHIFT  = 18;
    localparam int unsigned XS_TAKE   = 27;
    localparam int unsigned ROT_SHIFT = 59;

    // item modes
    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_BOUNDED = 2'd1;
    localparam logic [1:0] MODE_LOAD    = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL_LL = 6'b000010,
        ST_MUL_LH = 6'b000100,
        ST_MUL_HL = 6'b001000,
        ST_ACC    = 6'b010000,
        ST_HOLD   = 6'b100000
    } pcg_state_t;

    // control from sequencer to datapath
    typedef struct packed {
        logic ready;
        logic issue_ll;
        logic issue_lh;
        logic issue_hl;
        logic acc_first;
        logic acc_upper;
        logic state_upd;
        logic out_load;
    } pcg_ctrl_t;

    // xsh-rr permutation of the old state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
        logic [STATE_W-1:0] mixed;
        logic [WORD_W-1:0]  xs;
        logic [4:0]         rot;
        logic [2*WORD_W-1:0] dbl;
        mixed = ((old >> XS_SHIFT) ^ old) >> XS_TAKE;
        xs    = mixed[WORD_W-1:0];
        rot   = old[STATE_W-1:ROT_SHIFT];
        dbl   = {xs, xs} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

    // all ones from the highest set bit down
    function automatic logic [WORD_W-1:0] smear_mask(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] s;
        s = v;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s;
    endfunction

endpackage

>>> sv/pcg32_if.sv
// item channel interfaces of the pcg32 bounded index unit
interface pcg32_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] bound;
    logic [63:0] seed_value;

    modport source (output valid, output mode, output bound, output seed_value, input ready);
    modport sink   (input valid, input mode, input bound, input seed_value, output ready);
endinterface

interface pcg32_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> sv/pcg32_mul.sv
// shared 32x32 multiplier with registered product
module pcg32_mul
    import pcg32_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [WORD_W-1:0]   op_a,
    input  logic [WORD_W-1:0]   op_b,
    output logic [2*WORD_W-1:0] prod
);

    logic [2*WORD_W-1:0] prod_reg;
    logic [2*WORD_W-1:0] prod_next;

    // one partial product per cycle while en is high
    assign prod_next = {{WORD_W{1'b0}}, op_a} * {{WORD_W{1'b0}}, op_b};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> sv/pcg32_seq.sv
// sequencer for draws, rejection retries and result hand-off
module pcg32_seq
    import pcg32_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      start_draw,
    input  logic      reject,
    input  logic      out_free,
    output pcg_ctrl_t ctrl
);

`include "pcg32_bounded_index_unit_assert.svh"

    pcg_state_t state_reg;
    pcg_state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = start_draw ? ST_MUL_LL : ST_HOLD;
                end
            end
            ST_MUL_LL: state_next = ST_MUL_LH;
            ST_MUL_LH: state_next = ST_MUL_HL;
            ST_MUL_HL: state_next = ST_ACC;
            ST_ACC:    state_next = reject ? ST_MUL_LL : ST_HOLD;
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control decode
    always_comb
    begin
        ctrl.ready     = (state_reg == ST_IDLE);
        ctrl.issue_ll  = (state_reg == ST_MUL_LL);
        ctrl.issue_lh  = (state_reg == ST_MUL_LH);
        ctrl.issue_hl  = (state_reg == ST_MUL_HL);
        ctrl.acc_first = (state_reg == ST_MUL_LH);
        ctrl.acc_upper = (state_reg == ST_MUL_HL);
        ctrl.state_upd = (state_reg == ST_ACC);
        ctrl.out_load  = (state_reg == ST_HOLD) && out_free;
    end

    // checks
    `PCG_ASSERT_NEXT(a_draw_start, start && start_draw, state_reg == ST_MUL_LL, "draw item did not start multiply")
    `PCG_ASSERT_NEXT(a_nodraw_hold, start && !start_draw, state_reg == ST_HOLD, "load item did not go to hold")
    `PCG_ASSERT_NEXT(a_retry, state_reg == ST_ACC && reject, state_reg == ST_MUL_LL, "rejected draw not retried")
    `PCG_ASSERT_NEXT(a_mul_order, state_reg == ST_MUL_LL, state_reg == ST_MUL_LH ##1 state_reg == ST_MUL_HL, "multiply steps out of order")
    `PCG_ASSERT_NEXT(a_hold_stall, state_reg == ST_HOLD && !out_free, state_reg == ST_HOLD, "result dropped while output busy")

endmodule

>>> sv/pcg32_bounded_index_unit.sv
// top level: pcg32 generator with unbiased bounded index drawing
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    mode[1:0], bound[31:0], seed_value[63:0]
//  out_ch    out  valid / ready    value[31:0]
//  cfg       in   cfg_we           cfg_wdata[63:0] (stream increment)
//
// one draw is three 32x32 partial products through the shared multiplier
// and a final accumulate into the 64-bit state
// raw draw: accept, draw, then hold until ready again; bounded draw: accept, draw,
// and a rejected draw is retried before the hold; load and unused modes: accept, then hold
// a stalled output holds the sequencer in its hold step until the output register frees
// reset loads the default state and increment; no clearing pass
module pcg32_bounded_index_unit
    import pcg32_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pcg32_in_if.sink             in_ch,
    pcg32_out_if.source          out_ch,
    input  logic                 cfg_we,
    input  logic [STATE_W-1:0]   cfg_wdata
);

    pcg_ctrl_t ctrl;

    logic [STATE_W-1:0]  gen_state_reg;
    logic [STATE_W-1:0]  gen_state_next;
    logic [STATE_W-1:0]  inc_reg;
    logic [STATE_W-1:0]  acc_reg;
    logic [STATE_W-1:0]  acc_next;
    logic [1:0]          mode_reg;
    logic [WORD_W-1:0]   lim_reg;
    logic [WORD_W-1:0]   mask_reg;
    logic [WORD_W-1:0]   draw_reg;
    logic [WORD_W-1:0]   draw_next;
    logic [WORD_W-1:0]   out_value_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                start;
    logic                start_draw;
    logic                reject;
    logic                out_free;
    logic [WORD_W-1:0]   lim_in;
    logic [WORD_W-1:0]   op_a;
    logic [WORD_W-1:0]   op_b;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0]   upper_sum;
    logic                mul_en;

    // handshake decode
    assign start      = in_ch.valid && ctrl.ready;
    assign start_draw = (in_ch.mode == MODE_RAW) || (in_ch.mode == MODE_BOUNDED);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign lim_in     = in_ch.bound - 1'b1;
    assign reject     = (mode_reg == MODE_BOUNDED) && (draw_reg > lim_reg);

    pcg32_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_draw (start_draw),
        .reject     (reject),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    // operand select for the shared multiplier
    assign op_a   = ctrl.issue_hl ? gen_state_reg[STATE_W-1:WORD_W] : gen_state_reg[WORD_W-1:0];
    assign op_b   = ctrl.issue_lh ? LCG_MULT_HI : LCG_MULT_LO;
    assign mul_en = ctrl.issue_ll || ctrl.issue_lh || ctrl.issue_hl;

    pcg32_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // cross products only reach the upper word
    assign upper_sum = acc_reg[STATE_W-1:WORD_W] + prod[WORD_W-1:0];

    // accumulator: low product plus odd increment, then the first cross term; the second is added on the state update
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_first)
        begin
            acc_next = prod + {inc_reg[STATE_W-1:1], 1'b1};
        end
        else if (ctrl.acc_upper)
        begin
            acc_next = {upper_sum, acc_reg[WORD_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // generator state
    always_comb
    begin
        gen_state_next = gen_state_reg;
        if (start && (in_ch.mode == MODE_LOAD))
        begin
            gen_state_next = in_ch.seed_value;
        end
        else if (ctrl.state_upd)
        begin
            gen_state_next = {upper_sum, acc_reg[WORD_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= STATE_RESET;
            inc_reg       <= INC_RESET;
        end
        else
        begin
            gen_state_reg <= gen_state_next;
            if (cfg_we)
            begin
                inc_reg <= cfg_wdata;
            end
        end
    end

    // item capture: limit and mask for bounded draws
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= in_ch.mode;
            lim_reg  <= lim_in;
            mask_reg <= (in_ch.mode == MODE_BOUNDED) ? smear_mask(lim_in | 32'd1)
                                                     : {WORD_W{1'b1}};
        end
    end

    // masked draw from the old state, zero for non-draw items
    always_comb
    begin
        draw_next = draw_reg;
        if (start && !start_draw)
        begin
            draw_next = '0;
        end
        else if (ctrl.issue_ll)
        begin
            draw_next = xsh_rr(gen_state_reg) & mask_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg <= draw_next;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_value_reg <= draw_reg;
        end
    end

    assign in_ch.ready  = ctrl.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.value = out_value_reg;

endmodule
